@@ rtl/rhse_pkg.sv @@
// Shared types, constants and modular helpers for the rolling hash engine.
package rhse_pkg;

    localparam int HASH_W = 61;
    localparam int IDX_W  = 13;
    localparam int CHR_W  = 8;
    localparam int OP_W   = 3;

    localparam logic [HASH_W-1:0] HMOD = {HASH_W{1'b1}};

    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
    localparam logic [OP_W-1:0] OP_SUBSTR = 3'd2;
    localparam logic [OP_W-1:0] OP_JOIN   = 3'd3;
    localparam logic [OP_W-1:0] OP_LCP    = 3'd4;

    typedef enum logic [4:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_CLEAR,
        ACT_ERR,
        ACT_ZERO,
        ACT_APP_RD,
        ACT_APP_MUL1,
        ACT_APP_MUL2,
        ACT_APP_WR,
        ACT_JOIN_RD,
        ACT_JOIN_MUL,
        ACT_JOIN_FIN,
        ACT_SUB_INIT,
        ACT_LCP_INIT,
        ACT_PROBE_A,
        ACT_PROBE_B,
        ACT_SH_RD1,
        ACT_SH_RD2,
        ACT_SH_CAP,
        ACT_SH_FIN,
        ACT_LCP_STEP,
        ACT_LCP_MID,
        ACT_LCP_DONE,
        ACT_PUB
    } t_act;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            bad_a;
        logic            bad_b;
        logic            empty;
        logic            join_bad;
        logic            mul_done;
        logic            lcp_fin;
    } t_dp_st;

    function automatic logic [HASH_W-1:0] canon(input logic [HASH_W-1:0] v);
        return (v == HMOD) ? '0 : v;
    endfunction

    function automatic logic [HASH_W-1:0] madd(input logic [HASH_W-1:0] a,
                                               input logic [HASH_W-1:0] b);
        logic [HASH_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, HMOD}) s = s - {1'b0, HMOD};
        return s[HASH_W-1:0];
    endfunction

    function automatic logic [HASH_W-1:0] msub(input logic [HASH_W-1:0] a,
                                               input logic [HASH_W-1:0] b);
        logic [HASH_W:0] t;
        t = {1'b0, a};
        if (a < b) t = t + {1'b0, HMOD};
        t = t - {1'b0, b};
        return t[HASH_W-1:0];
    endfunction

endpackage

@@ rtl/rolling_hash_substring_engine_unit.sv @@
// Top level of the rolling hash substring engine.
// Polynomial hash modulo 2^61-1 over a stored string of up to MAX_LEN signed
// bytes, with prefix-hash and power tables in two RAMs. One item is worked at
// a time; a new item is taken once the previous result sits in the output
// register, even if that result has not been taken yet. Every modular multiply
// uses one shared 31x31 multiplier, and table reads and multiplies run one
// after another. LCP makes at most 1 + ceil(log2(shorter span length)) hash
// probes. Configure the base only while idle and with the string cleared.
module rolling_hash_substring_engine_unit
    import rhse_pkg::*;
#(
    parameter int MAX_LEN = 4096
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_base_we,
    input  logic [HASH_W-1:0]       i_base,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [OP_W-1:0]         i_op,
    input  logic signed [CHR_W-1:0] i_char_value,
    input  logic [IDX_W-1:0]        i_left_a,
    input  logic [IDX_W-1:0]        i_right_a,
    input  logic [IDX_W-1:0]        i_left_b,
    input  logic [IDX_W-1:0]        i_right_b,
    input  logic [HASH_W-1:0]       i_hash_one,
    input  logic [HASH_W-1:0]       i_hash_two,
    input  logic [IDX_W-1:0]        i_join_length,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [HASH_W-1:0]       o_hash_value,
    output logic [IDX_W-1:0]        o_lcp_length,
    output logic                    o_error_flag
);
    t_act   act;
    t_dp_st st;

    rhse_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_st    (st),
        .o_act   (act),
        .o_stall (o_stall),
        .o_valid (o_valid)
    );

    rhse_dp #(.MAX_LEN(MAX_LEN)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_act         (act),
        .o_st          (st),
        .i_base_we     (i_base_we),
        .i_base        (i_base),
        .i_op          (i_op),
        .i_char_value  (i_char_value),
        .i_left_a      (i_left_a),
        .i_right_a     (i_right_a),
        .i_left_b      (i_left_b),
        .i_right_b     (i_right_b),
        .i_hash_one    (i_hash_one),
        .i_hash_two    (i_hash_two),
        .i_join_length (i_join_length),
        .o_hash_value  (o_hash_value),
        .o_lcp_length  (o_lcp_length),
        .o_error_flag  (o_error_flag)
    );
endmodule

@@ rtl/rhse_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rhse_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

@@ rtl/rhse_mulmod.sv @@
// Multi-cycle multiplier modulo 2^61-1 built on one 31x31 multiplier.
module rhse_mulmod
    import rhse_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [HASH_W-1:0] i_a,
    input  logic [HASH_W-1:0] i_b,
    output logic [HASH_W-1:0] o_res,
    output logic              o_done
);
    logic [HASH_W-1:0] r_a, r_b, r_res;
    logic [2:0]        r_step;
    logic              r_done;
    logic [61:0]       r_pp, r_mid;
    logic [63:0]       r_acc;
    logic [30:0]       mx, my;
    logic [61:0]       prod;
    logic [61:0]       fsum;
    logic [HASH_W-1:0] fres;

    always_comb begin
        case (r_step)
            3'd1:    begin mx = r_a[30:0];          my = r_b[30:0];          end
            3'd2:    begin mx = r_a[30:0];          my = {1'b0, r_b[60:31]}; end
            3'd3:    begin mx = {1'b0, r_a[60:31]}; my = r_b[30:0];          end
            3'd4:    begin mx = {1'b0, r_a[60:31]}; my = {1'b0, r_b[60:31]}; end
            default: begin mx = '0;                 my = '0;                 end
        endcase
    end

    assign prod = mx * my;
    assign fsum = {1'b0, r_acc[60:0]} + {59'd0, r_acc[63:61]};
    assign fres = (fsum >= {1'b0, HMOD}) ? 61'(fsum - {1'b0, HMOD}) : fsum[HASH_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_step == 3'd7);
            if (i_start) r_step <= 3'd1;
            else if (r_step == 3'd7) r_step <= '0;
            else if (r_step != '0) r_step <= r_step + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        r_pp <= prod;
        case (r_step)
            3'd2:    r_acc <= {2'b00, r_pp};
            3'd3:    r_mid <= r_pp;
            3'd4:    r_mid <= r_mid + r_pp;
            3'd5:    r_acc <= r_acc + {1'b0, r_pp, 1'b0};
            3'd6:    r_acc <= r_acc + {32'd0, r_mid[61:30]} + {2'b00, r_mid[29:0], 31'd0};
            3'd7:    r_res <= fres;
            default: r_acc <= r_acc;
        endcase
    end

    assign o_res  = r_res;
    assign o_done = r_done;
endmodule

@@ rtl/rhse_dp.sv @@
// Datapath: operand and result registers, hash tables, modular arithmetic.
module rhse_dp
    import rhse_pkg::*;
#(
    parameter int MAX_LEN = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_act                     i_act,
    output t_dp_st                   o_st,
    input  logic                     i_base_we,
    input  logic [HASH_W-1:0]        i_base,
    input  logic [OP_W-1:0]          i_op,
    input  logic signed [CHR_W-1:0]  i_char_value,
    input  logic [IDX_W-1:0]         i_left_a,
    input  logic [IDX_W-1:0]         i_right_a,
    input  logic [IDX_W-1:0]         i_left_b,
    input  logic [IDX_W-1:0]         i_right_b,
    input  logic [HASH_W-1:0]        i_hash_one,
    input  logic [HASH_W-1:0]        i_hash_two,
    input  logic [IDX_W-1:0]         i_join_length,
    output logic [HASH_W-1:0]        o_hash_value,
    output logic [IDX_W-1:0]         o_lcp_length,
    output logic                     o_error_flag
);
    localparam int D  = MAX_LEN + 1;
    localparam int LW = $clog2(D);
    localparam int CW = (LW > IDX_W) ? LW : IDX_W;

    logic [LW-1:0]     r_len;
    logic [HASH_W-1:0] r_base;
    logic [OP_W-1:0]   r_op;
    logic [CHR_W-1:0]  r_cv;
    logic [IDX_W-1:0]  r_la, r_ra, r_lb, r_rb, r_jl;
    logic [HASH_W-1:0] r_h1, r_h2;
    logic [HASH_W-1:0] r_t, r_u, r_h, r_ha;
    logic [IDX_W-1:0]  r_l, r_m, r_mid, r_good, r_bad, r_lmin;
    logic              r_first, r_fin;
    logic [HASH_W-1:0] r_hv, r_ohv;
    logic [IDX_W-1:0]  r_lcp, r_olcp;
    logic              r_err, r_oerr;
    logic              r_p0, r_w0;

    logic [LW-1:0]     p_raddr, w_raddr, waddr;
    logic              tbl_we;
    logic [HASH_W-1:0] p_q, w_q, p_data, w_data, app_h, chr;
    logic              m_start, m_done;
    logic [HASH_W-1:0] m_a, m_b, m_res;
    logic [IDX_W:0]    sh_r;
    logic [IDX_W-1:0]  da, db;

    assign sh_r  = {1'b0, r_l} + {1'b0, r_m};
    assign da    = r_ra - r_la;
    assign db    = r_rb - r_lb;
    assign chr   = r_cv[CHR_W-1] ? (HMOD - 61'(9'd256 - {1'b0, r_cv})) : 61'(r_cv);
    assign app_h = madd(r_u, chr);
    assign waddr = r_len + LW'(1);
    assign tbl_we = (i_act == ACT_APP_WR);
    assign p_data = r_p0 ? '0 : p_q;
    assign w_data = r_w0 ? 61'd1 : w_q;

    always_comb begin
        p_raddr = '0;
        w_raddr = '0;
        m_start = 1'b0;
        m_a     = '0;
        m_b     = '0;
        case (i_act)
            ACT_APP_RD: begin
                p_raddr = r_len;
                w_raddr = r_len;
            end
            ACT_JOIN_RD: w_raddr = LW'(r_jl);
            ACT_SH_RD1: begin
                p_raddr = LW'(r_l);
                w_raddr = LW'(r_m);
            end
            ACT_SH_RD2: begin
                p_raddr = LW'(sh_r);
                m_start = 1'b1;
                m_a     = p_data;
                m_b     = w_data;
            end
            ACT_APP_MUL1: begin
                m_start = 1'b1;
                m_a     = p_data;
                m_b     = r_base;
            end
            ACT_APP_MUL2: begin
                m_start = 1'b1;
                m_a     = r_t;
                m_b     = r_base;
            end
            ACT_JOIN_MUL: begin
                m_start = 1'b1;
                m_a     = r_h1;
                m_b     = w_data;
            end
            default: m_start = 1'b0;
        endcase
    end

    rhse_ram #(.W(HASH_W), .D(D)) u_prefix (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (waddr),
        .i_wdata (app_h),
        .i_raddr (p_raddr),
        .o_rdata (p_q)
    );

    rhse_ram #(.W(HASH_W), .D(D)) u_power (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (waddr),
        .i_wdata (m_res),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    rhse_mulmod u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (m_start),
        .i_a     (m_a),
        .i_b     (m_b),
        .o_res   (m_res),
        .o_done  (m_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_base <= '0;
        end else begin
            if (i_base_we) r_base <= canon(i_base);
            if (i_act == ACT_CLEAR) r_len <= '0;
            else if (i_act == ACT_APP_WR) r_len <= waddr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0 <= (p_raddr == '0);
        r_w0 <= (w_raddr == '0);
        case (i_act)
            ACT_LOAD: begin
                r_op <= i_op;
                r_cv <= i_char_value;
                r_la <= i_left_a;
                r_ra <= i_right_a;
                r_lb <= i_left_b;
                r_rb <= i_right_b;
                r_h1 <= canon(i_hash_one);
                r_h2 <= canon(i_hash_two);
                r_jl <= i_join_length;
            end
            ACT_CLEAR, ACT_ZERO: begin
                r_hv <= '0; r_lcp <= '0; r_err <= 1'b0;
            end
            ACT_ERR: begin
                r_hv <= '0; r_lcp <= '0; r_err <= 1'b1;
            end
            ACT_APP_MUL1: r_t <= w_data;
            ACT_APP_MUL2: r_u <= m_res;
            ACT_APP_WR: begin
                r_hv <= app_h; r_lcp <= '0; r_err <= 1'b0;
            end
            ACT_JOIN_FIN: begin
                r_hv <= madd(m_res, r_h2); r_lcp <= '0; r_err <= 1'b0;
            end
            ACT_SUB_INIT: begin
                r_l <= r_la;
                r_m <= da;
            end
            ACT_LCP_INIT: begin
                r_lmin  <= (da < db) ? da : db;
                r_mid   <= (da < db) ? da : db;
                r_bad   <= (da < db) ? da : db;
                r_good  <= '0;
                r_first <= 1'b1;
                r_fin   <= 1'b0;
            end
            ACT_PROBE_A: begin
                r_l <= r_la;
                r_m <= r_mid;
            end
            ACT_PROBE_B: begin
                r_l  <= r_lb;
                r_m  <= r_mid;
                r_ha <= r_h;
            end
            ACT_SH_CAP: r_t <= p_data;
            ACT_SH_FIN: begin
                r_h   <= msub(r_t, m_res);
                r_hv  <= msub(r_t, m_res);
                r_lcp <= '0;
                r_err <= 1'b0;
            end
            ACT_LCP_STEP: begin
                r_first <= 1'b0;
                if (r_ha == r_h) begin
                    if (r_first) r_fin <= 1'b1;
                    else r_good <= r_mid;
                end else begin
                    r_bad <= r_mid;
                end
            end
            ACT_LCP_MID: r_mid <= IDX_W'(({1'b0, r_good} + {1'b0, r_bad}) >> 1);
            ACT_LCP_DONE: begin
                r_hv  <= '0;
                r_lcp <= r_fin ? r_lmin : r_good;
                r_err <= 1'b0;
            end
            ACT_PUB: begin
                r_ohv  <= r_hv;
                r_olcp <= r_lcp;
                r_oerr <= r_err;
            end
            default: r_t <= r_t;
        endcase
    end

    assign o_st.op       = r_op;
    assign o_st.full     = (r_len == LW'(MAX_LEN));
    assign o_st.bad_a    = (r_la > r_ra) || (CW'(r_ra) > CW'(r_len));
    assign o_st.bad_b    = (r_lb > r_rb) || (CW'(r_rb) > CW'(r_len));
    assign o_st.empty    = (r_la == r_ra) || (r_lb == r_rb);
    assign o_st.join_bad = (CW'(r_jl) > CW'(r_len));
    assign o_st.mul_done = m_done;
    assign o_st.lcp_fin  = r_fin || ((r_bad - r_good) <= IDX_W'(1));

    assign o_hash_value = r_ohv;
    assign o_lcp_length = r_olcp;
    assign o_error_flag = r_oerr;
endmodule

@@ rtl/rhse_ctrl.sv @@
// Controller: sequences table reads, multiplies and the LCP search.
module rhse_ctrl
    import rhse_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  logic   i_stall,
    input  t_dp_st i_st,
    output t_act   o_act,
    output logic   o_stall,
    output logic   o_valid
);
    typedef enum logic [4:0] {
        S_IDLE, S_DEC, S_APP_M1, S_APP_W1, S_APP_W2, S_JOIN_M, S_JOIN_W,
        S_PRB_A, S_PRB_B, S_SH_RD1, S_SH_RD2, S_SH_CAP, S_SH_W,
        S_LCP_STEP, S_LCP_CHK, S_PUB
    } t_state;

    typedef enum logic [1:0] {RET_SUB, RET_A, RET_B} t_ret;

    t_state r_state, n_state;
    t_ret   r_ret, n_ret;
    logic   r_ovalid, n_ovalid;
    logic   pub;
    t_act   act;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        act     = ACT_NONE;
        pub     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    act     = ACT_LOAD;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_PUB;
                act     = ACT_ERR;
                case (i_st.op)
                    OP_CLEAR: act = ACT_CLEAR;
                    OP_APPEND: begin
                        if (!i_st.full) begin
                            act     = ACT_APP_RD;
                            n_state = S_APP_M1;
                        end
                    end
                    OP_SUBSTR: begin
                        if (!i_st.bad_a) begin
                            act     = ACT_SUB_INIT;
                            n_ret   = RET_SUB;
                            n_state = S_SH_RD1;
                        end
                    end
                    OP_JOIN: begin
                        if (!i_st.join_bad) begin
                            act     = ACT_JOIN_RD;
                            n_state = S_JOIN_M;
                        end
                    end
                    OP_LCP: begin
                        if (!i_st.bad_a && !i_st.bad_b) begin
                            if (i_st.empty) begin
                                act = ACT_ZERO;
                            end else begin
                                act     = ACT_LCP_INIT;
                                n_state = S_PRB_A;
                            end
                        end
                    end
                    default: act = ACT_ERR;
                endcase
            end
            S_APP_M1: begin
                act     = ACT_APP_MUL1;
                n_state = S_APP_W1;
            end
            S_APP_W1: begin
                if (i_st.mul_done) begin
                    act     = ACT_APP_MUL2;
                    n_state = S_APP_W2;
                end
            end
            S_APP_W2: begin
                if (i_st.mul_done) begin
                    act     = ACT_APP_WR;
                    n_state = S_PUB;
                end
            end
            S_JOIN_M: begin
                act     = ACT_JOIN_MUL;
                n_state = S_JOIN_W;
            end
            S_JOIN_W: begin
                if (i_st.mul_done) begin
                    act     = ACT_JOIN_FIN;
                    n_state = S_PUB;
                end
            end
            S_PRB_A: begin
                act     = ACT_PROBE_A;
                n_ret   = RET_A;
                n_state = S_SH_RD1;
            end
            S_PRB_B: begin
                act     = ACT_PROBE_B;
                n_ret   = RET_B;
                n_state = S_SH_RD1;
            end
            S_SH_RD1: begin
                act     = ACT_SH_RD1;
                n_state = S_SH_RD2;
            end
            S_SH_RD2: begin
                act     = ACT_SH_RD2;
                n_state = S_SH_CAP;
            end
            S_SH_CAP: begin
                act     = ACT_SH_CAP;
                n_state = S_SH_W;
            end
            S_SH_W: begin
                if (i_st.mul_done) begin
                    act = ACT_SH_FIN;
                    case (r_ret)
                        RET_SUB: n_state = S_PUB;
                        RET_A:   n_state = S_PRB_B;
                        default: n_state = S_LCP_STEP;
                    endcase
                end
            end
            S_LCP_STEP: begin
                act     = ACT_LCP_STEP;
                n_state = S_LCP_CHK;
            end
            S_LCP_CHK: begin
                if (i_st.lcp_fin) begin
                    act     = ACT_LCP_DONE;
                    n_state = S_PUB;
                end else begin
                    act     = ACT_LCP_MID;
                    n_state = S_PRB_A;
                end
            end
            S_PUB: begin
                if (!r_ovalid || !i_stall) begin
                    act     = ACT_PUB;
                    pub     = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_ovalid = pub | (r_ovalid & i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= RET_SUB;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_act   = act;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
endmodule

@@ rtl/rhse_checker.sv @@
// Port-level checks for the rolling hash engine, bound to the top level.
module rhse_props
    import rhse_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    o_stall,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic [HASH_W-1:0]       o_hash_value,
    input logic [IDX_W-1:0]        o_lcp_length,
    input logic                    o_error_flag
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hash_value)
            && $stable(o_lcp_length) && $stable(o_error_flag))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("block not busy after taking an item");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_flag |-> o_hash_value == '0 && o_lcp_length == '0)
        else $error("rejected item carries data");

    a_lcp_no_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_lcp_length != '0 |-> o_hash_value == '0 && !o_error_flag)
        else $error("lcp result carries a hash");

    a_hash_canon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_hash_value != HMOD)
        else $error("hash not reduced");
endmodule

bind rolling_hash_substring_engine_unit rhse_props u_rhse_props (.*);

@@ tb/rhse_checker.sv @@
// Predicts the rolling hash engine's results and compares each accepted result item.
`timescale 1ns / 1ps
module rhse_checker
    import rhse_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    base_we,
    input  logic [HASH_W-1:0]       base_in,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [OP_W-1:0]         op,
    input  logic signed [CHR_W-1:0] char_value,
    input  logic [IDX_W-1:0]        left_a,
    input  logic [IDX_W-1:0]        right_a,
    input  logic [IDX_W-1:0]        left_b,
    input  logic [IDX_W-1:0]        right_b,
    input  logic [HASH_W-1:0]       hash_one,
    input  logic [HASH_W-1:0]       hash_two,
    input  logic [IDX_W-1:0]        join_length,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic [HASH_W-1:0]       hash_value,
    input  logic [IDX_W-1:0]        lcp_length,
    input  logic                    error_flag,
    output int                      errors,
    output int                      pending
);

    localparam int STR_MAX = 4096;

    typedef struct {
        logic [HASH_W-1:0] hash;
        logic [IDX_W-1:0]  lcp;
        logic              err;
    } t_hash_result;

    logic [HASH_W-1:0] prefix_hash [0:STR_MAX];
    logic [HASH_W-1:0] base_pow [0:STR_MAX];
    int unsigned       str_len;
    logic [HASH_W-1:0] hash_base;
    t_hash_result      expected_q[$];

    function automatic logic [HASH_W-1:0] fix(input logic [HASH_W-1:0] v);
        return (v == HMOD) ? '0 : v;
    endfunction

    function automatic logic [HASH_W-1:0] mulmod(input logic [HASH_W-1:0] a,
                                                 input logic [HASH_W-1:0] b);
        logic [2*HASH_W-1:0] p;
        p = {{HASH_W{1'b0}}, a} * {{HASH_W{1'b0}}, b};
        p = p % {{HASH_W{1'b0}}, HMOD};
        return p[HASH_W-1:0];
    endfunction

    function automatic logic [HASH_W-1:0] addmod(input logic [HASH_W-1:0] a,
                                                 input logic [HASH_W-1:0] b);
        logic [HASH_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, HMOD}) s = s - {1'b0, HMOD};
        return s[HASH_W-1:0];
    endfunction

    function automatic logic [HASH_W-1:0] submod(input logic [HASH_W-1:0] a,
                                                 input logic [HASH_W-1:0] b);
        logic [HASH_W:0] t;
        t = {1'b0, a} + {1'b0, HMOD} - {1'b0, b};
        if (t >= {1'b0, HMOD}) t = t - {1'b0, HMOD};
        return t[HASH_W-1:0];
    endfunction

    function automatic logic [HASH_W-1:0] span_hash(input int unsigned l, input int unsigned r);
        return submod(prefix_hash[r], mulmod(prefix_hash[l], base_pow[r-l]));
    endfunction

    function automatic logic span_ok(input int unsigned l, input int unsigned r);
        return l <= r && r <= str_len;
    endfunction

    task automatic run_op(output t_hash_result res);
        int unsigned la, ra, lb, rb, n, good, bad, mid;
        logic [HASH_W-1:0] c;
        la = left_a;
        ra = right_a;
        lb = left_b;
        rb = right_b;
        res = '{hash: '0, lcp: '0, err: 1'b0};
        case (op)
            OP_CLEAR: str_len = 0;
            OP_APPEND: begin
                if (str_len >= STR_MAX) begin
                    res.err = 1'b1;
                end else begin
                    if (char_value < 0)
                        c = HMOD - HASH_W'(-int'(char_value));
                    else
                        c = HASH_W'(char_value);
                    n = str_len;
                    prefix_hash[n+1] = addmod(mulmod(prefix_hash[n], hash_base), c);
                    base_pow[n+1] = mulmod(base_pow[n], hash_base);
                    str_len = n + 1;
                    res.hash = prefix_hash[n+1];
                end
            end
            OP_SUBSTR: begin
                if (span_ok(la, ra)) res.hash = span_hash(la, ra);
                else res.err = 1'b1;
            end
            OP_JOIN: begin
                if (join_length <= str_len)
                    res.hash = addmod(mulmod(fix(hash_one), base_pow[join_length]),
                                      fix(hash_two));
                else
                    res.err = 1'b1;
            end
            OP_LCP: begin
                if (!span_ok(la, ra) || !span_ok(lb, rb)) begin
                    res.err = 1'b1;
                end else if (la != ra && lb != rb) begin
                    n = (ra - la) < (rb - lb) ? (ra - la) : (rb - lb);
                    if (span_hash(la, la + n) == span_hash(lb, lb + n)) begin
                        res.lcp = IDX_W'(n);
                    end else begin
                        good = 0;
                        bad = n;
                        while (bad - good > 1) begin
                            mid = (good + bad) / 2;
                            if (span_hash(la, la + mid) == span_hash(lb, lb + mid)) good = mid;
                            else bad = mid;
                        end
                        res.lcp = IDX_W'(good);
                    end
                end
            end
            default: res.err = 1'b1;
        endcase
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        $display("tb: mismatch in %s: got %0h, want %0h at %0t", what, got, exp, $realtime);
        errors++;
    endtask

    initial begin
        errors = 0;
        pending = 0;
    end

    always @(posedge clk) begin
        t_hash_result want, got_res;
        if (!rst_n) begin
            prefix_hash[0] = '0;
            base_pow[0] = 1;
            str_len = 0;
            hash_base = '0;
            expected_q.delete();
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    report("unexpected item", 64'(hash_value), 64'd0);
                end else begin
                    want = expected_q.pop_front();
                    if (hash_value !== want.hash)
                        report("hash_value", 64'(hash_value), 64'(want.hash));
                    if (lcp_length !== want.lcp)
                        report("lcp_length", 64'(lcp_length), 64'(want.lcp));
                    if (error_flag !== want.err)
                        report("error_flag", 64'(error_flag), 64'(want.err));
                end
            end
            if (base_we) hash_base = fix(base_in);
            if (in_valid && !in_stall) begin
                run_op(got_res);
                expected_q.push_back(got_res);
            end
        end
        pending = expected_q.size();
    end

endmodule

@@ tb/tb.sv @@
// Top testbench for the rolling hash engine: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
module tb;
    import rhse_pkg::*;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_base_we;
    logic [HASH_W-1:0]       i_base;
    logic                    i_valid;
    logic                    o_stall;
    logic [OP_W-1:0]         i_op;
    logic signed [CHR_W-1:0] i_char_value;
    logic [IDX_W-1:0]        i_left_a, i_right_a, i_left_b, i_right_b;
    logic [HASH_W-1:0]       i_hash_one, i_hash_two;
    logic [IDX_W-1:0]        i_join_length;
    logic                    o_valid;
    logic                    i_stall;
    logic [HASH_W-1:0]       o_hash_value;
    logic [IDX_W-1:0]        o_lcp_length;
    logic                    o_error_flag;

    int  errors, pending;
    int  taken;
    logic quiet;
    int  cur_len;

    rolling_hash_substring_engine_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_base_we(i_base_we), .i_base(i_base),
        .i_valid(i_valid), .o_stall(o_stall), .i_op(i_op), .i_char_value(i_char_value),
        .i_left_a(i_left_a), .i_right_a(i_right_a), .i_left_b(i_left_b),
        .i_right_b(i_right_b), .i_hash_one(i_hash_one), .i_hash_two(i_hash_two),
        .i_join_length(i_join_length), .o_valid(o_valid), .i_stall(i_stall),
        .o_hash_value(o_hash_value), .o_lcp_length(o_lcp_length),
        .o_error_flag(o_error_flag)
    );

    rhse_checker u_check (
        .clk(i_clk), .rst_n(i_rst_n), .base_we(i_base_we), .base_in(i_base),
        .in_valid(i_valid), .in_stall(o_stall), .op(i_op), .char_value(i_char_value),
        .left_a(i_left_a), .right_a(i_right_a), .left_b(i_left_b), .right_b(i_right_b),
        .hash_one(i_hash_one), .hash_two(i_hash_two), .join_length(i_join_length),
        .out_valid(o_valid), .out_stall(i_stall), .hash_value(o_hash_value),
        .lcp_length(o_lcp_length), .error_flag(o_error_flag),
        .errors(errors), .pending(pending)
    );

    initial i_clk = 1'b0;
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_valid && !o_stall) taken <= taken + 1;
    end

    always @(negedge i_clk) begin
        i_stall = i_rst_n && !quiet && ($urandom_range(0, 99) < 36);
    end

    initial begin
        #50_000_000;
        $display("tb: errors");
        $finish;
    end

    function automatic logic [HASH_W-1:0] rand_hash();
        case ($urandom_range(0, 9))
            0: return HMOD;
            1: return HMOD - 1;
            2: return '0;
            default: return HASH_W'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] rand_idx(input int len);
        if ($urandom_range(0, 9) == 0) return IDX_W'($urandom_range(0, 8191));
        return IDX_W'($urandom_range(0, len));
    endfunction

    task automatic send(input logic [OP_W-1:0] op, input logic [CHR_W-1:0] cv,
                        input logic [IDX_W-1:0] la, input logic [IDX_W-1:0] ra,
                        input logic [IDX_W-1:0] lb, input logic [IDX_W-1:0] rb,
                        input logic [HASH_W-1:0] h1, input logic [HASH_W-1:0] h2,
                        input logic [IDX_W-1:0] jl);
        int target;
        if (!quiet && $urandom_range(0, 99) < 36) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_op = op;
        i_char_value = cv;
        i_left_a = la;
        i_right_a = ra;
        i_left_b = lb;
        i_right_b = rb;
        i_hash_one = h1;
        i_hash_two = h2;
        i_join_length = jl;
        i_valid = 1'b1;
        target = taken + 1;
        do @(negedge i_clk); while (taken != target);
        if (op == OP_CLEAR) cur_len = 0;
        if (op == OP_APPEND && cur_len < 4096) cur_len++;
    endtask

    task automatic drain();
        i_valid = 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_base(input logic [HASH_W-1:0] v);
        send(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
        drain();
        i_base_we = 1'b1;
        i_base = v;
        @(negedge i_clk);
        i_base_we = 1'b0;
    endtask

    task automatic send_substr(input int l, input int r);
        send(OP_SUBSTR, CHR_W'($urandom), IDX_W'(l), IDX_W'(r), rand_idx(8191),
             rand_idx(8191), rand_hash(), rand_hash(), rand_idx(8191));
    endtask

    task automatic send_lcp(input int la, input int ra, input int lb, input int rb);
        send(OP_LCP, CHR_W'($urandom), IDX_W'(la), IDX_W'(ra), IDX_W'(lb), IDX_W'(rb),
             rand_hash(), rand_hash(), rand_idx(8191));
    endtask

    task automatic send_append(input logic [CHR_W-1:0] cv);
        send(OP_APPEND, cv, rand_idx(8191), rand_idx(8191), rand_idx(8191),
             rand_idx(8191), rand_hash(), rand_hash(), rand_idx(8191));
    endtask

    task automatic random_query();
        int k, la, ra, lb, rb, t;
        k = $urandom_range(0, 99);
        la = rand_idx(cur_len);
        ra = rand_idx(cur_len);
        lb = rand_idx(cur_len);
        rb = rand_idx(cur_len);
        if ($urandom_range(0, 99) < 85) begin
            if (la > ra) begin t = la; la = ra; ra = t; end
            if (lb > rb) begin t = lb; lb = rb; rb = t; end
        end
        if (k < 2) begin
            send(OP_CLEAR, CHR_W'($urandom), IDX_W'(la), IDX_W'(ra), IDX_W'(lb),
                 IDX_W'(rb), rand_hash(), rand_hash(), rand_idx(8191));
        end else if (k < 4) begin
            send(OP_W'($urandom_range(5, 7)), CHR_W'($urandom), IDX_W'(la), IDX_W'(ra),
                 IDX_W'(lb), IDX_W'(rb), rand_hash(), rand_hash(), rand_idx(8191));
        end else if (k < 16) begin
            send_append(($urandom_range(0, 1) == 0) ? CHR_W'($urandom_range(97, 98))
                                                     : CHR_W'($urandom));
        end else if (k < 40) begin
            send_substr(la, ra);
        end else if (k < 60) begin
            send(OP_JOIN, CHR_W'($urandom), IDX_W'(la), IDX_W'(ra), IDX_W'(lb),
                 IDX_W'(rb), rand_hash(), rand_hash(), rand_idx(cur_len));
        end else begin
            send_lcp(la, ra, lb, rb);
        end
    endtask

    initial begin
        logic [HASH_W-1:0] bases [6];
        int n;
        taken = 0;
        cur_len = 0;
        quiet = 1'b0;
        i_rst_n = 1'b0;
        i_base_we = 1'b0;
        i_base = '0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_op = OP_CLEAR;
        i_char_value = '0;
        i_left_a = '0;
        i_right_a = '0;
        i_left_b = '0;
        i_right_b = '0;
        i_hash_one = '0;
        i_hash_two = '0;
        i_join_length = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send(OP_JOIN, 0, 0, 0, 0, 0, HMOD, HMOD - 1, 0);
        send(OP_JOIN, 0, 0, 0, 0, 0, 5, 6, 1);
        send_lcp(0, 0, 0, 0);
        set_base(61'd131);
        send_append(8'sd127);
        send_append(-8'sd128);
        send_append(8'sd0);
        send_append(8'sd127);
        send_append(-8'sd128);
        send_substr(0, 5);
        send_substr(1, 4);
        send_substr(3, 2);
        send_substr(0, 6);
        send(OP_JOIN, 0, 0, 0, 0, 0, HMOD, HMOD - 1, 5);
        send(OP_JOIN, 0, 0, 0, 0, 0, 1, 2, 8191);
        send_lcp(0, 2, 3, 5);
        send_lcp(0, 5, 1, 5);
        send_lcp(2, 2, 0, 5);
        send_lcp(0, 6, 0, 1);
        send_lcp(0, 1, 4, 3);
        send(OP_W'(5), 0, 0, 0, 0, 0, 0, 0, 0);
        send(OP_W'(6), 0, 0, 0, 0, 0, 0, 0, 0);
        send(OP_W'(7), 0, 0, 0, 0, 0, 0, 0, 0);

        bases = '{61'd0, HMOD, HMOD - 1, 61'd1, HASH_W'({$urandom, $urandom}),
                  HASH_W'({$urandom, $urandom})};
        for (int ph = 0; ph < 6; ph++) begin
            quiet = (ph == 2);
            set_base(bases[ph]);
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 30);
            repeat (n) send_append(($urandom_range(0, 2) != 0) ? CHR_W'($urandom_range(97, 98))
                                                               : CHR_W'($urandom));
            for (int i = 0; i < 110; i++) begin
                random_query();
                if (ph == 3 && i == 50) drain();
            end
        end
        quiet = 1'b0;

        drain();
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
